// ===== rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and helper functions of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    // default parameter values
    localparam int POOL_ORDER_MAX_DEF = 16;
    localparam int MIN_ORDER_DEF      = 5;
    localparam int HEADER_BYTES_DEF   = 20;

    // pool order after reset, before clamping
    localparam int POOL_ORDER_RESET = 16;
    // distance from block start to payload
    localparam int PAYLOAD_SKIP     = 4;

    // header entry layout: start flag, busy flag, 5-bit order
    localparam int ORD_W   = 5;
    localparam int HDR_W   = 7;
    localparam int HDR_STA = 6;
    localparam int HDR_BSY = 5;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [15:0] request_bytes;
        logic [15:0] free_offset;
    } in_t;

    typedef struct packed {
        logic             ok;
        logic [15:0]      payload_offset;
        logic [ORD_W-1:0] block_order;
    } out_t;

    // datapath commands
    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLR,
        DP_LOAD,
        DP_NEXT,
        DP_TAKE,
        DP_SPLIT,
        DP_MARK,
        DP_RD_BUD,
        DP_MERGE,
        DP_FREE_DONE,
        DP_FAIL,
        DP_PUB
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic bad;
        logic is_free;
        logic scan_fit;
        logic scan_bad;
        logic scan_end;
        logic split_more;
        logic slot_ok;
        logic at_top;
        logic bud_ok;
        logic clr_last;
    } dp_status_t;

    // clamp a written pool order into the legal range
    function automatic logic [ORD_W-1:0] clamp_order(logic [ORD_W-1:0] v, int lo, int hi);
        logic [ORD_W-1:0] r;
        r = v;
        if (int'(v) < lo) r = ORD_W'(lo);
        if (int'(v) > hi) r = ORD_W'(hi);
        return r;
    endfunction

    // smallest order whose block holds the request plus header
    function automatic logic [ORD_W-1:0] need_order(logic [15:0] req, int hdr, int lo);
        logic [17:0]      need;
        logic [ORD_W-1:0] k;
        need = 18'(req) + 18'(hdr);
        k    = '1;
        for (int i = 31; i >= lo; i--) begin
            if ((33'(1) << i) >= 33'(need)) k = ORD_W'(i);
        end
        return k;
    endfunction

endpackage

// ===== rtl/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/bba_datapath.sv =====
// ----------------------------------------------------------------------------
// bba_datapath
// Header store, scan and merge pointers, request decode and result registers.
// ----------------------------------------------------------------------------
module bba_datapath #(
    parameter int POOL_ORDER_MAX = bba_pkg::POOL_ORDER_MAX_DEF,
    parameter int MIN_ORDER      = bba_pkg::MIN_ORDER_DEF,
    parameter int HEADER_BYTES   = bba_pkg::HEADER_BYTES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bba_pkg::dp_cmd_t            cmd,
    output bba_pkg::dp_status_t         st,
    input  bba_pkg::in_t                s_data,
    input  logic                        cfg_wr,
    input  logic [bba_pkg::ORD_W-1:0]   cfg_data,
    output bba_pkg::out_t               m_data
);

    localparam int SLOT_W = POOL_ORDER_MAX - MIN_ORDER;
    localparam int SLOT_COUNT = 1 << SLOT_W;
    localparam int ORD_LO = (MIN_ORDER > 6) ? MIN_ORDER : 6;
    localparam int OW = bba_pkg::ORD_W;

    logic [OW-1:0]          pool_order_reg;
    logic [SLOT_W-1:0]      clr_cnt_reg;
    logic                   op_reg;
    logic                   bad_reg;
    logic [OW-1:0]          k_reg;
    logic [OW-1:0]          ord_reg;
    logic [SLOT_W:0]        pos_reg;
    bba_pkg::out_t          res_reg;
    bba_pkg::out_t          m_data_reg;

    logic                   we;
    logic [SLOT_W-1:0]      waddr;
    logic [SLOT_W-1:0]      raddr;
    logic [bba_pkg::HDR_W-1:0] wdata;
    logic [bba_pkg::HDR_W-1:0] rdata;

    logic [15:0]            start16;
    logic [31:0]            slot32;
    logic                   free_bad;
    logic [OW-1:0]          k_in;
    logic                   h_start;
    logic                   h_busy;
    logic [OW-1:0]          h_ord;
    logic                   ord_ok;
    logic [SLOT_W:0]        blk_step;
    logic [SLOT_W:0]        scan_next;
    logic [SLOT_W:0]        slots;
    logic [SLOT_W-1:0]      bud;
    logic [SLOT_W-1:0]      split_addr;
    logic [31:0]            pos_off;
    logic [15:0]            payload16;

    // header store, one entry per minimum-size slot
    bba_ram #(
        .WIDTH (bba_pkg::HDR_W),
        .DEPTH (SLOT_COUNT)
    ) u_hdr_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // request decode
    always_comb begin
        start16  = s_data.free_offset - 16'(bba_pkg::PAYLOAD_SKIP);
        slot32   = 32'(start16) >> MIN_ORDER;
        free_bad = (s_data.free_offset < 16'(bba_pkg::PAYLOAD_SKIP))
                || ((32'(start16) & ((32'(1) << MIN_ORDER) - 32'(1))) != 32'(0))
                || ((32'(start16) >> pool_order_reg) != 32'(0));
        k_in     = bba_pkg::need_order(s_data.request_bytes, HEADER_BYTES, MIN_ORDER);
    end

    // header decode and pointer arithmetic
    always_comb begin
        h_start    = rdata[bba_pkg::HDR_STA];
        h_busy     = rdata[bba_pkg::HDR_BSY];
        h_ord      = rdata[OW-1:0];
        ord_ok     = (h_ord >= OW'(MIN_ORDER)) && (h_ord <= pool_order_reg);
        blk_step   = (SLOT_W+1)'(1) << (h_ord - OW'(MIN_ORDER));
        scan_next  = pos_reg + blk_step;
        slots      = (SLOT_W+1)'(1) << (pool_order_reg - OW'(MIN_ORDER));
        bud        = pos_reg[SLOT_W-1:0] ^ (SLOT_W'(1) << (ord_reg - OW'(MIN_ORDER)));
        split_addr = pos_reg[SLOT_W-1:0]
                   + (SLOT_W'(1) << (ord_reg - OW'(MIN_ORDER) - OW'(1)));
        pos_off    = 32'(pos_reg) << MIN_ORDER;
        payload16  = pos_off[15:0] + 16'(bba_pkg::PAYLOAD_SKIP);
    end

    // status towards the controller
    always_comb begin
        st.bad        = bad_reg;
        st.is_free    = (op_reg == bba_pkg::OP_FREE);
        st.scan_fit   = h_start && ord_ok && !h_busy && (h_ord >= k_reg);
        st.scan_bad   = !(h_start && ord_ok);
        st.scan_end   = (scan_next >= slots);
        st.split_more = (ord_reg > k_reg);
        st.slot_ok    = h_start && h_busy && ord_ok;
        st.at_top     = (ord_reg >= pool_order_reg);
        st.bud_ok     = h_start && !h_busy && (h_ord == ord_reg);
        st.clr_last   = &clr_cnt_reg;
    end

    // store port selection
    always_comb begin
        we    = 1'b0;
        waddr = pos_reg[SLOT_W-1:0];
        wdata = '0;
        raddr = pos_reg[SLOT_W-1:0];
        case (cmd.op)
            bba_pkg::DP_CLR: begin
                we    = 1'b1;
                waddr = clr_cnt_reg;
                wdata = (clr_cnt_reg == '0) ? {2'b10, pool_order_reg} : '0;
            end
            bba_pkg::DP_SPLIT: begin
                we    = 1'b1;
                waddr = split_addr;
                wdata = {2'b10, ord_reg - OW'(1)};
            end
            bba_pkg::DP_MARK: begin
                we    = 1'b1;
                wdata = {2'b11, k_reg};
            end
            bba_pkg::DP_RD_BUD: begin
                raddr = bud;
            end
            bba_pkg::DP_MERGE: begin
                we    = 1'b1;
                waddr = (bud > pos_reg[SLOT_W-1:0]) ? bud : pos_reg[SLOT_W-1:0];
            end
            bba_pkg::DP_FREE_DONE: begin
                we    = 1'b1;
                wdata = {2'b10, ord_reg};
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // configuration and clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_order_reg <= bba_pkg::clamp_order(OW'(bba_pkg::POOL_ORDER_RESET),
                                                   ORD_LO, POOL_ORDER_MAX);
            clr_cnt_reg    <= '0;
        end else if (cfg_wr) begin
            pool_order_reg <= bba_pkg::clamp_order(cfg_data, ORD_LO, POOL_ORDER_MAX);
            clr_cnt_reg    <= '0;
        end else if (cmd.op == bba_pkg::DP_CLR) begin
            clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
        end
    end

    // working registers and results
    always_ff @(posedge aclk) begin
        case (cmd.op)
            bba_pkg::DP_LOAD: begin
                op_reg  <= s_data.operation;
                k_reg   <= k_in;
                bad_reg <= (s_data.operation == bba_pkg::OP_FREE) ? free_bad
                                                                  : (k_in > pool_order_reg);
                pos_reg <= (s_data.operation == bba_pkg::OP_FREE) ? slot32[SLOT_W:0] : '0;
            end
            bba_pkg::DP_NEXT:  pos_reg <= scan_next;
            bba_pkg::DP_TAKE:  ord_reg <= h_ord;
            bba_pkg::DP_SPLIT: ord_reg <= ord_reg - OW'(1);
            bba_pkg::DP_MARK:  res_reg <= '{ok: 1'b1, payload_offset: payload16,
                                            block_order: k_reg};
            bba_pkg::DP_MERGE: begin
                if (bud < pos_reg[SLOT_W-1:0]) pos_reg <= {1'b0, bud};
                ord_reg <= ord_reg + OW'(1);
            end
            bba_pkg::DP_FREE_DONE: res_reg <= '{ok: 1'b1, payload_offset: payload16,
                                                block_order: ord_reg};
            bba_pkg::DP_FAIL:  res_reg <= '0;
            bba_pkg::DP_PUB:   m_data_reg <= res_reg;
            default: begin
                res_reg <= res_reg;
            end
        endcase
    end

    assign m_data = m_data_reg;

endmodule

// ===== rtl/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for clearing, allocate scan and split, free and buddy merge.
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 cfg_wr,
    input  logic                 cfg_valid,
    output bba_pkg::dp_cmd_t     cmd,
    input  bba_pkg::dp_status_t  st
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_RD_SCAN,
        S_EV_SCAN,
        S_SPLIT,
        S_EV_SLOT,
        S_MERGE_CHK,
        S_EV_BUD,
        S_POST
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // next state and command
    always_comb begin
        state_next = state_reg;
        cmd.op     = bba_pkg::DP_NOP;
        case (state_reg)
            S_CLEAR: begin
                cmd.op = bba_pkg::DP_CLR;
                if (st.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid && !cfg_valid) begin
                    cmd.op     = bba_pkg::DP_LOAD;
                    state_next = S_START;
                end
            end
            S_START: begin
                if (st.bad) begin
                    cmd.op     = bba_pkg::DP_FAIL;
                    state_next = S_POST;
                end else if (st.is_free) begin
                    state_next = S_EV_SLOT;
                end else begin
                    state_next = S_EV_SCAN;
                end
            end
            S_RD_SCAN: state_next = S_EV_SCAN;
            S_EV_SCAN: begin
                if (st.scan_bad) begin
                    cmd.op     = bba_pkg::DP_FAIL;
                    state_next = S_POST;
                end else if (st.scan_fit) begin
                    cmd.op     = bba_pkg::DP_TAKE;
                    state_next = S_SPLIT;
                end else if (st.scan_end) begin
                    cmd.op     = bba_pkg::DP_FAIL;
                    state_next = S_POST;
                end else begin
                    cmd.op     = bba_pkg::DP_NEXT;
                    state_next = S_RD_SCAN;
                end
            end
            S_SPLIT: begin
                if (st.split_more) begin
                    cmd.op = bba_pkg::DP_SPLIT;
                end else begin
                    cmd.op     = bba_pkg::DP_MARK;
                    state_next = S_POST;
                end
            end
            S_EV_SLOT: begin
                if (st.slot_ok) begin
                    cmd.op     = bba_pkg::DP_TAKE;
                    state_next = S_MERGE_CHK;
                end else begin
                    cmd.op     = bba_pkg::DP_FAIL;
                    state_next = S_POST;
                end
            end
            S_MERGE_CHK: begin
                if (st.at_top) begin
                    cmd.op     = bba_pkg::DP_FREE_DONE;
                    state_next = S_POST;
                end else begin
                    cmd.op     = bba_pkg::DP_RD_BUD;
                    state_next = S_EV_BUD;
                end
            end
            S_EV_BUD: begin
                if (st.bud_ok) begin
                    cmd.op     = bba_pkg::DP_MERGE;
                    state_next = S_MERGE_CHK;
                end else begin
                    cmd.op     = bba_pkg::DP_FREE_DONE;
                    state_next = S_POST;
                end
            end
            S_POST: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op     = bba_pkg::DP_PUB;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
        if (cfg_wr) state_next = S_CLEAR;
    end

    // output valid tracking
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.op == bba_pkg::DP_PUB) m_valid_next = 1'b1;
        else if (m_ready)              m_valid_next = 1'b0;
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE) && !cfg_valid;
    assign m_valid = m_valid_reg;

    // a configuration write always starts a clearing sweep
    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> !s_ready)
        else $error("input taken straight after configuration write");

    // only one request in flight
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");

    // a result is never published over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == bba_pkg::DP_PUB) |-> (!m_valid_reg || m_ready))
        else $error("pending result overwritten");

    // the last sweep step leads to idle
    a_clear_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) && st.clr_last && !cfg_wr |=> (state_reg == S_IDLE))
        else $error("clearing sweep did not finish");

endmodule

// ===== rtl/buddy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a power-of-two pool with a per-slot header store.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel (valid/ready): operation 0 allocates
// request_bytes plus header, operation 1 frees the block at free_offset.
// Each request gives one result transfer on the m_ channel: ok, the payload
// offset and the block order (all zero on failure or an invalid free).
// The cfg_ channel writes pool_order; every write restarts a clearing sweep.
// One request is handled at a time. An allocate scans the headers in
// address order, takes the first free block of sufficient order and splits
// it down to the needed order; a free checks that the slot holds a busy
// block start, then merges it with its buddy while the buddy is free and of
// the same order, until the pool order is reached. The result is written to
// a result register and then published to the output register, where
// m_valid marks it.
// After reset and after each pool_order write the header store is swept,
// one slot a cycle, 2^(POOL_ORDER_MAX-MIN_ORDER) slots (2048 by default),
// with s_ready low. If the receiver stalls, the result stays in the output
// register, and the next request is still taken and worked on up to its
// own result, which then waits until the output register is free.
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
    parameter int POOL_ORDER_MAX = bba_pkg::POOL_ORDER_MAX_DEF,
    parameter int MIN_ORDER      = bba_pkg::MIN_ORDER_DEF,
    parameter int HEADER_BYTES   = bba_pkg::HEADER_BYTES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  bba_pkg::in_t              s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output bba_pkg::out_t             m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [bba_pkg::ORD_W-1:0] cfg_data
);

    bba_pkg::dp_cmd_t    cmd;
    bba_pkg::dp_status_t st;
    logic                cfg_wr;

    // configuration transfers are always taken
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    bba_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_wr    (cfg_wr),
        .cfg_valid (cfg_valid),
        .cmd       (cmd),
        .st        (st)
    );

    bba_datapath #(
        .POOL_ORDER_MAX (POOL_ORDER_MAX),
        .MIN_ORDER      (MIN_ORDER),
        .HEADER_BYTES   (HEADER_BYTES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .st       (st),
        .s_data   (s_data),
        .cfg_wr   (cfg_wr),
        .cfg_data (cfg_data),
        .m_data   (m_data)
    );

endmodule
